>>> hdl/ssp_pkg.sv
// Shared types, constants and helper functions for the stereo sector packer.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package ssp_pkg;

   localparam int SUBBLOCKS           = 4;
   localparam int FRAMES_PER_SUBBLOCK = 16;
   localparam int STEMS               = 4;

   localparam int PAIR_BYTES    = 6;
   localparam int TRAILER_BYTES = 8;
   localparam int AUDIO_BYTES   = FRAMES_PER_SUBBLOCK * STEMS * PAIR_BYTES;
   localparam int SLOT_BYTES    = AUDIO_BYTES + TRAILER_BYTES;

   localparam int ADDR_W   = 18;
   localparam int SB_W     = 3;
   localparam int FRAME_W  = 8;
   localparam int STEM_W   = 4;
   localparam int SLOT_W   = 4;
   localparam int PAIR_W   = FRAME_W + STEM_W;
   localparam int BIDX_W   = 3;
   localparam int BYTES_W  = 64;

   localparam logic [31:0] ORDER_RESET = 32'h7654_3210;

   localparam logic [BIDX_W-1:0] LAST_ERROR   = BIDX_W'(0);
   localparam logic [BIDX_W-1:0] LAST_SAMPLE  = BIDX_W'(PAIR_BYTES - 1);
   localparam logic [BIDX_W-1:0] LAST_TRAILER = BIDX_W'(TRAILER_BYTES - 1);

   localparam logic OP_SAMPLE  = 1'b0;
   localparam logic OP_TRAILER = 1'b1;

   // One decoded item as it travels from the front to the back.
   typedef struct packed {
      logic                order_error;
      logic                sector_end;
      logic [ADDR_W-1:0]   base_addr;
      logic [BIDX_W-1:0]   last_idx;
      logic [BYTES_W-1:0]  bytes;     // byte k in bits 8k+7..8k, emitted in k order
   } cmd_type;

   // Saturate a signed 32-bit sample to signed 24 bits.
   function automatic logic [23:0] sat24(input logic [31:0] s);
      logic [23:0] r;
      if ((s[31:23] == 9'h000) || (s[31:23] == 9'h1FF)) begin
         r = s[23:0];
      end else if (s[31]) begin
         r = 24'h80_0000;
      end else begin
         r = 24'h7F_FFFF;
      end
      return r;
   endfunction

endpackage

>>> hdl/stereo_sector_packer_core.sv
// Top level of the stereo sector packer: front end, command queue, back end.
// Depends on ssp_pkg, ssp_front, ssp_queue and ssp_back.
//
// Usage:
//   The req_ channel carries one item per transfer: a stem sample pair
//   (opcode 0) or a subblock trailer (opcode 1). The rsp_ channel carries one
//   addressed byte write per transfer. A sample gives six transfers, a
//   trailer eight, and an item of the wrong kind a single error transfer.
//   csr_wr_en/csr_wr_data load the slot order register; write it only while
//   the block is idle.
//   An accepted item passes through the queue entry, the current-command
//   register and the single byte-wide output register before its first
//   result is valid. The back loads the next item as the last byte leaves.
//   A two-entry queue lets the front keep accepting while the back drains.
//   When the receiver stalls, the output holds steady, the queue fills and
//   req_stall rises. Reset clears the sector position, empties the queue and
//   output, and restores the slot order to its default; there is no
//   clearing pass.
`timescale 1ns / 1ps

module stereo_sector_packer_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wr_en,
   input  logic [31:0]                 csr_wr_data,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_opcode,
   input  logic signed [31:0]          req_left_sample,
   input  logic signed [31:0]          req_right_sample,
   input  logic [15:0]                 req_sync_word,
   input  logic [15:0]                 req_tempo_word,
   input  logic [31:0]                 req_led_bytes,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_write_valid,
   output logic [ssp_pkg::ADDR_W-1:0]  rsp_byte_address,
   output logic [7:0]                  rsp_byte_value,
   output logic                        rsp_last_of_run,
   output logic                        rsp_sector_end,
   output logic                        rsp_order_error
);

   ssp_pkg::cmd_type front_cmd, head_cmd;
   logic             q_full, q_not_empty, q_pop, accept;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   ssp_front u_front (
      .clock        (clock),
      .reset        (reset),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .accept       (accept),
      .opcode       (req_opcode),
      .left_sample  (req_left_sample),
      .right_sample (req_right_sample),
      .sync_word    (req_sync_word),
      .tempo_word   (req_tempo_word),
      .led_bytes    (req_led_bytes),
      .cmd          (front_cmd)
   );

   ssp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_cmd  (front_cmd),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head_cmd  (head_cmd)
   );

   ssp_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_not_empty      (q_not_empty),
      .q_cmd            (head_cmd),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_write_valid  (rsp_write_valid),
      .rsp_byte_address (rsp_byte_address),
      .rsp_byte_value   (rsp_byte_value),
      .rsp_last_of_run  (rsp_last_of_run),
      .rsp_sector_end   (rsp_sector_end),
      .rsp_order_error  (rsp_order_error)
   );

endmodule

>>> hdl/ssp_front.sv
// Front end: accepts items, checks their kind, tracks the sector position and
// builds one command per item. Holds the slot order register. Uses ssp_pkg.
`timescale 1ns / 1ps

module ssp_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_wr_en,
   input  logic [31:0]              csr_wr_data,
   input  logic                     accept,
   input  logic                     opcode,
   input  logic signed [31:0]       left_sample,
   input  logic signed [31:0]       right_sample,
   input  logic [15:0]              sync_word,
   input  logic [15:0]              tempo_word,
   input  logic [31:0]              led_bytes,
   output ssp_pkg::cmd_type         cmd
);

   logic [31:0]                     order_ff, order_in;
   logic [ssp_pkg::SB_W-1:0]        subblock_ff, subblock_in;
   logic [ssp_pkg::FRAME_W-1:0]     frame_ff, frame_in;
   logic [ssp_pkg::STEM_W-1:0]      stem_ff, stem_in;
   logic                            trailer_due_ff, trailer_due_in;

   logic [ssp_pkg::SLOT_W-1:0]      slot;
   logic [ssp_pkg::ADDR_W+3:0]      slot_base;
   logic [ssp_pkg::PAIR_W-1:0]      pair_idx;
   logic [ssp_pkg::PAIR_W+2:0]      pair_off;
   logic [ssp_pkg::ADDR_W-1:0]      sample_addr, trailer_addr;
   logic [23:0]                     lu, ru;
   logic                            kind_error;
   logic                            last_sb, last_stem, last_frame;

   always_comb begin
      slot      = order_ff[{subblock_ff, 2'b00} +: ssp_pkg::SLOT_W];
      slot_base = (ssp_pkg::ADDR_W+4)'(slot) * (ssp_pkg::ADDR_W+4)'(ssp_pkg::SLOT_BYTES);
      pair_idx  = ssp_pkg::PAIR_W'(frame_ff) * ssp_pkg::PAIR_W'(ssp_pkg::STEMS)
                  + ssp_pkg::PAIR_W'(stem_ff);
      pair_off  = (ssp_pkg::PAIR_W+3)'(pair_idx) * (ssp_pkg::PAIR_W+3)'(ssp_pkg::PAIR_BYTES);
      sample_addr  = slot_base[ssp_pkg::ADDR_W-1:0] + ssp_pkg::ADDR_W'(pair_off);
      trailer_addr = slot_base[ssp_pkg::ADDR_W-1:0]
                     + ssp_pkg::ADDR_W'(ssp_pkg::AUDIO_BYTES);

      lu = ssp_pkg::sat24(left_sample);
      ru = ssp_pkg::sat24(right_sample);

      kind_error = ((opcode == ssp_pkg::OP_TRAILER) != trailer_due_ff);
      last_sb    = (subblock_ff == ssp_pkg::SB_W'(ssp_pkg::SUBBLOCKS - 1));
      last_stem  = (stem_ff == ssp_pkg::STEM_W'(ssp_pkg::STEMS - 1));
      last_frame = (frame_ff == ssp_pkg::FRAME_W'(ssp_pkg::FRAMES_PER_SUBBLOCK - 1));

      cmd = '0;
      if (kind_error) begin
         cmd.order_error = 1'b1;
         cmd.last_idx    = ssp_pkg::LAST_ERROR;
      end else if (opcode == ssp_pkg::OP_SAMPLE) begin
         cmd.base_addr = sample_addr;
         cmd.last_idx  = ssp_pkg::LAST_SAMPLE;
         cmd.bytes     = {16'h0000, ru[15:8], ru[7:0], lu[7:0],
                          ru[23:16], lu[23:16], lu[15:8]};
      end else begin
         cmd.base_addr  = trailer_addr;
         cmd.last_idx   = ssp_pkg::LAST_TRAILER;
         cmd.sector_end = last_sb;
         cmd.bytes      = {led_bytes, tempo_word, sync_word};
      end
   end

   always_comb begin
      order_in       = csr_wr_en ? csr_wr_data : order_ff;
      subblock_in    = subblock_ff;
      frame_in       = frame_ff;
      stem_in        = stem_ff;
      trailer_due_in = trailer_due_ff;
      if (accept && !kind_error) begin
         if (opcode == ssp_pkg::OP_SAMPLE) begin
            if (last_stem) begin
               stem_in = '0;
               if (last_frame) begin
                  frame_in       = '0;
                  trailer_due_in = 1'b1;
               end else begin
                  frame_in = frame_ff + 1'b1;
               end
            end else begin
               stem_in = stem_ff + 1'b1;
            end
         end else begin
            trailer_due_in = 1'b0;
            frame_in       = '0;
            stem_in        = '0;
            subblock_in    = last_sb ? '0 : subblock_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff       <= ssp_pkg::ORDER_RESET;
         subblock_ff    <= '0;
         frame_ff       <= '0;
         stem_ff        <= '0;
         trailer_due_ff <= 1'b0;
      end else begin
         order_ff       <= order_in;
         subblock_ff    <= subblock_in;
         frame_ff       <= frame_in;
         stem_ff        <= stem_in;
         trailer_due_ff <= trailer_due_in;
      end
   end

endmodule

>>> hdl/ssp_queue.sv
// Two-entry command queue between the front and the back of the packer.
// Uses ssp_pkg for the command type.
`timescale 1ns / 1ps

module ssp_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  ssp_pkg::cmd_type push_cmd,
   output logic             full,
   input  logic             pop,
   output logic             not_empty,
   output ssp_pkg::cmd_type head_cmd
);

   ssp_pkg::cmd_type entry_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;

   always_comb begin
      full      = (count_ff == 2'd2);
      not_empty = (count_ff != 2'd0);
      head_cmd  = entry_ff[rd_ptr_ff];
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

>>> hdl/ssp_back.sv
// Back end: takes commands from the queue and emits them one byte write per
// transfer through a registered output stage. Uses ssp_pkg.
`timescale 1ns / 1ps

module ssp_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        q_not_empty,
   input  ssp_pkg::cmd_type            q_cmd,
   output logic                        q_pop,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_write_valid,
   output logic [ssp_pkg::ADDR_W-1:0]  rsp_byte_address,
   output logic [7:0]                  rsp_byte_value,
   output logic                        rsp_last_of_run,
   output logic                        rsp_sector_end,
   output logic                        rsp_order_error
);

   ssp_pkg::cmd_type             cur_ff, cur_in;
   logic                         cur_valid_ff, cur_valid_in;
   logic [ssp_pkg::BIDX_W-1:0]   idx_ff, idx_in;
   logic                         out_valid_ff, out_valid_in;
   logic                         out_wv_ff, out_wv_in;
   logic [ssp_pkg::ADDR_W-1:0]   out_addr_ff, out_addr_in;
   logic [7:0]                   out_byte_ff, out_byte_in;
   logic                         out_last_ff, out_last_in;
   logic                         out_send_ff, out_send_in;
   logic                         out_err_ff, out_err_in;

   logic                         advance, at_last, emit;

   always_comb begin
      advance = !out_valid_ff || !rsp_stall;
      at_last = (idx_ff == cur_ff.last_idx);
      emit    = advance && cur_valid_ff;
      // A new command loads when no command is held, or as the last byte leaves.
      q_pop   = q_not_empty && (!cur_valid_ff || (emit && at_last));

      cur_in       = q_pop ? q_cmd : cur_ff;
      cur_valid_in = cur_valid_ff;
      idx_in       = idx_ff;
      if (q_pop) begin
         cur_valid_in = 1'b1;
         idx_in       = '0;
      end else if (emit) begin
         if (at_last) begin
            cur_valid_in = 1'b0;
            idx_in       = '0;
         end else begin
            idx_in = idx_ff + 1'b1;
         end
      end

      out_valid_in = advance ? cur_valid_ff : out_valid_ff;
      out_wv_in    = out_wv_ff;
      out_addr_in  = out_addr_ff;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      out_send_in  = out_send_ff;
      out_err_in   = out_err_ff;
      if (emit) begin
         out_wv_in   = !cur_ff.order_error;
         out_addr_in = cur_ff.base_addr + ssp_pkg::ADDR_W'(idx_ff);
         out_byte_in = cur_ff.bytes[{idx_ff, 3'b000} +: 8];
         out_last_in = at_last;
         out_send_in = at_last && cur_ff.sector_end;
         out_err_in  = cur_ff.order_error;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      out_wv_ff   <= out_wv_in;
      out_addr_ff <= out_addr_in;
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
      out_send_ff <= out_send_in;
      out_err_ff  <= out_err_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_write_valid  = out_wv_ff;
   assign rsp_byte_address = out_addr_ff;
   assign rsp_byte_value   = out_byte_ff;
   assign rsp_last_of_run  = out_last_ff;
   assign rsp_sector_end   = out_send_ff;
   assign rsp_order_error  = out_err_ff;

endmodule
